// ===== design/rra_pkg.sv =====
// Shared types, codes and constants of the round-robin register allocator.
`default_nettype none
package rra_pkg;

  localparam int NUM_REAL_DEF = 32;
  localparam int NUM_REGS_DEF = 256;

  localparam int MASK_W    = 32;  // width of the class masks
  localparam int MID_W     = 5;   // id width of the mask search
  localparam int CNT_W     = 6;   // width of the real register count
  localparam int EPOCH_W   = 4;   // procedure tag stored with each map entry
  localparam int REG_W     = 8;   // register number width
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 32;

  typedef enum logic [1:0] {
    OP_BEGIN  = 2'd0,
    OP_USE    = 2'd1,
    OP_DEFINE = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_UNDEF = 3'd1,
    ST_RECL  = 3'd2,
    ST_REDEF = 3'd3,
    ST_NOREG = 3'd4,
    ST_ABORT = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOK,
    S_OWN,
    S_DONE
  } state_t;

  localparam logic [CFG_IDX_W-1:0] CFG_REAL_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INT_MASK   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FLOAT_MASK = 2'd2;

  typedef struct packed {
    logic             found;
    logic [MID_W-1:0] id;
  } pick_t;

endpackage
`default_nettype wire

// ===== design/rra_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module rra_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== design/rra_find.sv =====
// Round-robin search for the next usable register id of a class mask.
`default_nettype none
module rra_find (
  input  logic [rra_pkg::MASK_W-1:0] mask,
  input  logic [rra_pkg::CNT_W-1:0]  count,
  input  logic                       last_vld,
  input  logic [rra_pkg::MID_W-1:0]  last_id,
  output rra_pkg::pick_t             pick
);
  import rra_pkg::*;

  logic [CNT_W-1:0]  start;
  logic [MASK_W-1:0] avail;
  logic [MASK_W-1:0] upper;

  always_comb begin
    start = last_vld ? (CNT_W'(last_id) + CNT_W'(1)) : '0;
    if (start >= count) begin
      start = '0;
    end
    for (int i = 0; i < MASK_W; i++) begin
      avail[i] = mask[i] && (CNT_W'(i) < count);
      upper[i] = avail[i] && (CNT_W'(i) >= start);
    end
    // Lowest usable id at or after the start point, else the lowest overall.
    pick = '0;
    for (int i = MASK_W - 1; i >= 0; i--) begin
      if (avail[i]) begin
        pick.found = 1'b1;
        pick.id    = MID_W'(i);
      end
    end
    for (int i = MASK_W - 1; i >= 0; i--) begin
      if (upper[i]) begin
        pick.id = MID_W'(i);
      end
    end
  end

endmodule
`default_nettype wire

// ===== design/round_robin_register_allocator.sv =====
// Top level of the round-robin register allocator: sequencer, tables and ports.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------------------
//  in_     | slave     | in_tvalid/tready   | tdata: reg_num; tuser: op, is_float
//  out_    | master    | out_tvalid/tready  | tdata: reg_out; tuser: status
//  cfg_    | slave     | cfg_valid/ready    | cfg_index, cfg_data (register write)
//
// Each transaction is handled by a short sequencer around one map lookup: a
// use or a no-op passes from acceptance through S_LOOK and S_DONE back to
// S_IDLE, a define that allocates also passes S_OWN, which reads and rewrites
// the owner of the chosen register, and a begin goes straight to S_DONE, or first to S_CLEAR when the tag wraps.
// The map table is a RAM whose entries carry a procedure tag, so a begin only
// advances the tag; every sixteenth begin wraps the tag and triggers a clearing
// pass over all NUM_REGS map entries, and the same pass runs after reset.
// Reset is synchronous and active low. During a clearing pass no input
// transaction is accepted; configuration writes are always accepted.
// A finished result waits in the output register while out_tready is low and
// the sequencer holds until that register is free.
`default_nettype none
module round_robin_register_allocator #(
  parameter int NUM_REAL = rra_pkg::NUM_REAL_DEF,
  parameter int NUM_REGS = rra_pkg::NUM_REGS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // Input transaction: tdata[7:0] reg_num.
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [7:0]                    in_tdata,
  // tuser[1:0] op, tuser[2] is_float.
  input  logic [2:0]                    in_tuser,
  // Result transaction: tdata[7:0] reg_out.
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [7:0]                    out_tdata,
  // tuser[2:0] status.
  output logic [2:0]                    out_tuser,
  // Configuration write port.
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [rra_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rra_pkg::CFG_DAT_W-1:0] cfg_data
);
  import rra_pkg::*;

  // Real ids that can ever belong to a class: limited by the masks' width.
  localparam int ID_CNT = (NUM_REAL < MASK_W) ? NUM_REAL : MASK_W;
  localparam int ID_W   = $clog2(ID_CNT);
  localparam int VA_W   = $clog2(NUM_REGS);
  localparam int OA_W   = ID_W + 1;
  localparam int OWN_D  = 2 << ID_W;
  // Map entry layout, from the top: valid, reclaimed, real id, procedure tag.
  localparam int VM_W   = 2 + ID_W + EPOCH_W;
  localparam int VM_VLD = VM_W - 1;
  localparam int VM_RCL = VM_W - 2;

  // Configuration registers.
  logic [CNT_W-1:0]  real_cnt_r;
  logic [MASK_W-1:0] int_mask_r;
  logic [MASK_W-1:0] flt_mask_r;

  // Sequencer and procedure state.
  state_t             state_r, state_nxt;
  logic [EPOCH_W-1:0] epoch_r;
  logic               aborted_r;
  logic               pend_r;
  logic [VA_W-1:0]    clr_idx_r;
  logic [1:0]         last_vld_r;
  logic [1:0][MID_W-1:0] last_id_r;
  logic [1:0][ID_CNT-1:0] own_vld_r;

  // Current transaction and its pending result.
  op_t                op_r;
  logic [REG_W-1:0]   reg_r;
  logic               cls_r;
  logic [ID_W-1:0]    pick_id_r;
  logic [REG_W-1:0]   res_r;
  status_t            st_r;

  // Output register.
  logic               out_vld_r;
  logic [REG_W-1:0]   out_reg_r;
  status_t            out_st_r;

  // Table ports.
  logic               vm_we;
  logic [VA_W-1:0]    vm_waddr;
  logic [VM_W-1:0]    vm_wdata;
  logic [VM_W-1:0]    vm_rdata;
  logic               own_we;
  logic [OA_W-1:0]    own_raddr;
  logic [VA_W-1:0]    own_rdata;

  // Decision of the lookup cycle.
  logic [CNT_W-1:0]   n_eff;
  logic [CNT_W-1:0]   n_pass;
  logic               in_range;
  logic               vm_hit;
  logic               look_alloc;
  logic [REG_W-1:0]   look_res;
  status_t            look_st;
  pick_t              pick;

  logic               in_acc;
  logic               out_load;
  logic               epoch_wrap;
  logic               clr_last;

  assign cfg_ready  = 1'b1;
  assign in_acc     = in_tvalid && in_tready;
  assign epoch_wrap = (epoch_r == {EPOCH_W{1'b1}});
  assign clr_last   = (clr_idx_r == VA_W'(NUM_REGS - 1));

  // Numbers below the real count (capped at NUM_REAL) pass through, while only
  // ids below the masks' width can be allocated.
  assign n_pass   = (32'(real_cnt_r) > 32'(NUM_REAL)) ? CNT_W'(NUM_REAL) : real_cnt_r;
  assign n_eff    = (real_cnt_r > CNT_W'(ID_CNT)) ? CNT_W'(ID_CNT) : real_cnt_r;
  assign in_range = (32'(reg_r) < 32'(NUM_REGS));
  assign vm_hit   = vm_rdata[VM_VLD] && (vm_rdata[EPOCH_W-1:0] == epoch_r);

  rra_find u_find (
    .mask     (cls_r ? flt_mask_r : int_mask_r),
    .count    (n_eff),
    .last_vld (last_vld_r[cls_r]),
    .last_id  (last_id_r[cls_r]),
    .pick     (pick)
  );

  rra_ram #(
    .WIDTH (VM_W),
    .DEPTH (NUM_REGS)
  ) u_vmap (
    .clk   (clk),
    .we    (vm_we),
    .waddr (vm_waddr),
    .wdata (vm_wdata),
    .raddr (VA_W'(in_tdata)),
    .rdata (vm_rdata)
  );

  rra_ram #(
    .WIDTH (VA_W),
    .DEPTH (OWN_D)
  ) u_owner (
    .clk   (clk),
    .we    (own_we),
    .waddr ({cls_r, pick_id_r}),
    .wdata (VA_W'(reg_r)),
    .raddr (own_raddr),
    .rdata (own_rdata)
  );

  // Lookup decision: the map entry read at acceptance is valid in S_LOOK.
  always_comb begin
    look_alloc = 1'b0;
    look_res   = reg_r;
    look_st    = ST_OK;
    if (aborted_r) begin
      look_st = ST_ABORT;
    end else if (op_r == OP_NOP || reg_r < REG_W'(n_pass)) begin
      look_st = ST_OK;
    end else if (op_r == OP_USE) begin
      if (!in_range || !vm_hit) begin
        look_st = ST_UNDEF;
      end else if (vm_rdata[VM_RCL]) begin
        look_st = ST_RECL;
      end else begin
        look_res = REG_W'(vm_rdata[EPOCH_W +: ID_W]);
      end
    end else if (!in_range) begin
      look_st = ST_NOREG;
    end else if (vm_hit) begin
      look_st = ST_REDEF;
    end else if (!pick.found) begin
      look_st = ST_NOREG;
    end else begin
      look_alloc = 1'b1;
      look_res   = REG_W'(pick.id);
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (clr_last) begin
          state_nxt = pend_r ? S_DONE : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          if (op_t'(in_tuser[1:0]) == OP_BEGIN) begin
            state_nxt = epoch_wrap ? S_CLEAR : S_DONE;
          end else begin
            state_nxt = S_LOOK;
          end
        end
      end
      S_LOOK: state_nxt = look_alloc ? S_OWN : S_DONE;
      S_OWN:  state_nxt = S_DONE;
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Sequencer outputs: handshake and table write ports.
  always_comb begin
    in_tready = (state_r == S_IDLE);
    out_load  = (state_r == S_DONE) && (!out_vld_r || out_tready);
    vm_we     = 1'b0;
    vm_waddr  = VA_W'(reg_r);
    vm_wdata  = {1'b1, 1'b0, ID_W'(pick.id), epoch_r};
    own_we    = 1'b0;
    own_raddr = {cls_r, ID_W'(pick.id)};
    unique case (state_r)
      S_CLEAR: begin
        vm_we    = 1'b1;
        vm_waddr = clr_idx_r;
        vm_wdata = '0;
      end
      S_LOOK: begin
        vm_we = look_alloc;
      end
      S_OWN: begin
        // The previous owner keeps its entry but is marked reclaimed.
        vm_we    = own_vld_r[cls_r][pick_id_r];
        vm_waddr = own_rdata;
        vm_wdata = {1'b1, 1'b1, pick_id_r, epoch_r};
        own_we   = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      clr_idx_r  <= '0;
      pend_r     <= 1'b0;
      epoch_r    <= '0;
      aborted_r  <= 1'b0;
      last_vld_r <= '0;
      own_vld_r  <= '0;
      out_vld_r  <= 1'b0;
      real_cnt_r <= CNT_W'(32);
      int_mask_r <= '1;
      flt_mask_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) begin
        clr_idx_r <= clr_last ? '0 : clr_idx_r + VA_W'(1);
      end
      if (out_load) begin
        out_vld_r <= 1'b1;
        pend_r    <= 1'b0;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
      if (in_acc && op_t'(in_tuser[1:0]) == OP_BEGIN) begin
        epoch_r    <= epoch_r + EPOCH_W'(1);
        aborted_r  <= 1'b0;
        last_vld_r <= '0;
        own_vld_r  <= '0;
        pend_r     <= 1'b1;
      end
      if (state_r == S_LOOK && look_st != ST_OK && look_st != ST_ABORT) begin
        aborted_r <= 1'b1;
      end
      if (state_r == S_OWN) begin
        own_vld_r[cls_r][pick_id_r] <= 1'b1;
        last_vld_r[cls_r]           <= 1'b1;
        last_id_r[cls_r]            <= MID_W'(pick_id_r);
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_REAL_COUNT: real_cnt_r <= cfg_data[CNT_W-1:0];
          CFG_INT_MASK:   int_mask_r <= cfg_data[MASK_W-1:0];
          CFG_FLOAT_MASK: flt_mask_r <= cfg_data[MASK_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r  <= op_t'(in_tuser[1:0]);
      reg_r <= in_tdata;
      cls_r <= in_tuser[2];
      res_r <= '0;
      st_r  <= ST_OK;
    end
    if (state_r == S_LOOK) begin
      res_r     <= look_res;
      st_r      <= look_st;
      pick_id_r <= ID_W'(pick.id);
    end
    if (out_load) begin
      out_reg_r <= res_r;
      out_st_r  <= st_r;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_reg_r;
  assign out_tuser  = out_st_r;

`ifndef NO_ASSERTIONS
  // A finished result must never overwrite one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_vld_r || out_tready))
    else $error("result register overwritten while full");

  // Aborted results come only from an aborted procedure.
  a_abort_src: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LOOK && look_st == ST_ABORT) |-> aborted_r)
    else $error("aborted status without abort state");

  // A begin transaction clears the abort state.
  a_begin_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tuser[1:0] == OP_BEGIN) |=> !aborted_r)
    else $error("abort state survived a begin");

  // Ownership is only written for an id inside the allocation range.
  a_own_range: assert property (@(posedge clk) disable iff (!rst_n)
    own_we |-> (CNT_W'(pick_id_r) < n_eff))
    else $error("owner write outside allocation range");
`endif

endmodule
`default_nettype wire

// ===== tb/tb_round_robin_register_allocator.sv =====
// Self-checking testbench of the round-robin register allocator with its scoreboard.
`default_nettype none

module tb_round_robin_register_allocator;
  timeunit 1ns;
  timeprecision 1ps;

  import rra_pkg::*;

  localparam int REAL_IDS  = 32;      // real register ids of the default build
  localparam int VREGS     = 256;     // register numbers of the default build
  localparam int LIMIT     = 500000;  // cycle budget, far above the slowest legal run
  localparam int LONG_HOLD = 240;     // length of the one long receiver hold-off
  localparam int SUB_ITEMS = 100;     // random items per configuration setting

  // One expected result transaction.
  typedef struct {
    logic [7:0] reg_out;
    status_t    status;
  } alloc_result_t;

  // The scoreboard keeps its own copy of the allocator state and configuration.
  // Every accepted input transaction is turned into the result it must cause,
  // and every result transaction is compared with the oldest waiting one.
  class alloc_scoreboard;
    logic [5:0]    real_count;
    logic [31:0]   int_mask;
    logic [31:0]   fp_mask;
    bit            map_valid [VREGS];
    bit            map_recl  [VREGS];
    logic [4:0]    map_id    [VREGS];
    bit            owner_valid [2][REAL_IDS];
    logic [7:0]    owner_vreg  [2][REAL_IDS];
    bit            last_valid [2];
    logic [4:0]    last_id    [2];
    bit            aborted;
    alloc_result_t expected_q [$];
    int            failures;

    function new();
      real_count = 6'd32;
      int_mask   = '1;
      fp_mask    = '0;
      failures   = 0;
      clear_tables();
    endfunction

    // A begin transaction empties both tables and restarts both searches.
    function void clear_tables();
      for (int v = 0; v < VREGS; v++) begin
        map_valid[v] = 1'b0;
        map_recl[v]  = 1'b0;
        map_id[v]    = '0;
      end
      for (int c = 0; c < 2; c++) begin
        for (int i = 0; i < REAL_IDS; i++) begin
          owner_valid[c][i] = 1'b0;
          owner_vreg[c][i]  = '0;
        end
        last_valid[c] = 1'b0;
        last_id[c]    = '0;
      end
      aborted = 1'b0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
      case (idx)
        CFG_REAL_COUNT: real_count = data[5:0];
        CFG_INT_MASK:   int_mask   = data;
        CFG_FLOAT_MASK: fp_mask    = data;
        default: ;
      endcase
    endfunction

    function int usable_ids();
      return (real_count > REAL_IDS) ? REAL_IDS : int'(real_count);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Round-robin pick of the next register of one class for a define.
    function status_t allocate(logic [7:0] vreg, bit cls, output logic [4:0] picked);
      int          n;
      int          start;
      int          c;
      logic [31:0] mask;
      n      = usable_ids();
      mask   = cls ? fp_mask : int_mask;
      picked = '0;
      if (map_valid[vreg]) return ST_REDEF;
      if (n == 0) return ST_NOREG;
      start = last_valid[cls] ? int'(last_id[cls]) + 1 : 0;
      if (start >= n) start = 0;
      for (int i = 0; i < n; i++) begin
        c = start + i;
        if (c >= n) c -= n;
        if (mask[c]) begin
          // The previous owner of this register loses its value.
          if (owner_valid[cls][c]) map_recl[owner_vreg[cls][c]] = 1'b1;
          owner_valid[cls][c] = 1'b1;
          owner_vreg[cls][c]  = vreg;
          map_valid[vreg]     = 1'b1;
          map_recl[vreg]      = 1'b0;
          map_id[vreg]        = c[4:0];
          last_valid[cls]     = 1'b1;
          last_id[cls]        = c[4:0];
          picked              = c[4:0];
          return ST_OK;
        end
      end
      return ST_NOREG;
    endfunction

    function void note_input(op_t op, logic [7:0] num, logic is_float);
      alloc_result_t res;
      logic [4:0]    picked;
      res.reg_out = num;
      res.status  = ST_OK;
      if (op == OP_BEGIN) begin
        clear_tables();
        res.reg_out = '0;
      end else if (aborted) begin
        res.status = ST_ABORT;
      end else if (op == OP_NOP || num < usable_ids()) begin
        res.status = ST_OK;
      end else if (op == OP_USE) begin
        if (!map_valid[num])    res.status = ST_UNDEF;
        else if (map_recl[num]) res.status = ST_RECL;
        else                    res.reg_out = {3'b000, map_id[num]};
      end else begin
        res.status = allocate(num, is_float, picked);
        if (res.status == ST_OK) res.reg_out = {3'b000, picked};
      end
      // Any error aborts the rest of the procedure and echoes the number.
      if (res.status inside {ST_UNDEF, ST_RECL, ST_REDEF, ST_NOREG}) begin
        aborted     = 1'b1;
        res.reg_out = num;
      end
      expected_q.push_back(res);
    endfunction

    function void check_result(logic [7:0] got_reg, logic [2:0] got_status);
      alloc_result_t exp;
      if (expected_q.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("%0t: result with nothing expected: reg_out %0d status %0d",
                   $realtime, got_reg, got_status);
        return;
      end
      exp = expected_q.pop_front();
      if (got_reg !== exp.reg_out || got_status !== exp.status) begin
        failures++;
        if (failures <= 10)
          $display("%0t: mismatch: reg_out %0d status %0d, expected reg_out %0d status %0d (%s)",
                   $realtime, got_reg, got_status, exp.reg_out, exp.status,
                   exp.status.name());
      end
    endfunction
  endclass

  // Clock, reset and the ports of the block. Every input has a known value
  // from time zero on.
  logic                 clk;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [7:0]           in_tdata   = '0;   // [7:0] reg_num
  logic [2:0]           in_tuser   = '0;   // [1:0] op, [2] is_float
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [7:0]           out_tdata;         // [7:0] reg_out
  logic [2:0]           out_tuser;         // [2:0] status
  logic                 cfg_valid  = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [CFG_DAT_W-1:0] cfg_data   = '0;

  alloc_scoreboard sb;
  int              send_idle   = 0;   // percent of cycles the sender holds back
  int              recv_idle   = 0;   // percent of cycles the receiver stalls
  int              cur_count   = 32;  // real_count as last written
  logic            hold_req    = 1'b0;
  logic            hold_done   = 1'b0;
  int              hold_left   = 0;
  int              cycle_count = 0;

  round_robin_register_allocator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The run is bounded by a cycle budget. It counts the clearing passes after
  // reset and after every sixteenth begin, the long hold-off and heavy stalls.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT) begin
      $display("round_robin_register_allocator test failed");
      $finish;
    end
  end

  // Receiver side. It stalls at random at the rate of the current phase. Once
  // the main sequence asks for it, it holds off for a long stretch counted
  // here, so that the output register fills and the block stops taking input.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      hold_done  <= 1'b1;
      hold_left  <= LONG_HOLD;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Both channels are sampled at the clock edge, before any of the values
  // driven at that edge take effect. Results are checked before the input
  // of the same edge is noted; a result can never belong to that input.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);
      if (in_tvalid && in_tready) sb.note_input(op_t'(in_tuser[1:0]), in_tdata, in_tuser[2]);
    end
  end

  // Offers one input transaction and returns at the edge that accepts it.
  // tvalid stays high afterwards, so back-to-back transactions need no gap.
  task automatic send_item(input op_t op, input logic [7:0] num, input logic fl);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= num;
    in_tuser  <= {fl, op};
    do @(posedge clk); while (!in_tready);
  endtask

  // Lowers tvalid and waits until every expected result has arrived, then
  // lets the block settle back to idle.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Writes all three configuration registers back to back.
  task automatic set_config(input logic [31:0] count_word, input logic [31:0] imask,
                            input logic [31:0] fmask);
    logic [CFG_IDX_W-1:0] idx [3];
    logic [CFG_DAT_W-1:0] val [3];
    idx = '{CFG_REAL_COUNT, CFG_INT_MASK, CFG_FLOAT_MASK};
    val = '{count_word, imask, fmask};
    for (int k = 0; k < 3; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[k];
      cfg_data  <= val[k];
      do @(posedge clk); while (!cfg_ready);
      sb.write_reg(idx[k], val[k]);
    end
    cfg_valid <= 1'b0;
    cur_count = count_word[5:0];
  endtask

  // Random procedures: a begin, then defines of fresh virtual registers,
  // uses of registers defined earlier in the procedure, real registers that
  // pass through and no-ops. A few transactions are pure noise, which also
  // covers redefines, uses of undefined registers and the aborted state.
  task automatic run_procedures(input int n_items);
    int         sent;
    int         len;
    int         pick;
    int         eff;
    bit         known;
    logic [7:0] num;
    logic [7:0] defined_q [$];
    sent = 0;
    eff  = (cur_count > REAL_IDS) ? REAL_IDS : cur_count;
    while (sent < n_items) begin
      send_item(OP_BEGIN, 8'($urandom), 1'($urandom));
      sent++;
      defined_q.delete();
      len = $urandom_range(3, 20);
      repeat (len) begin
        pick = $urandom_range(99);
        if (pick < 6) begin
          send_item(op_t'($urandom_range(3)), 8'($urandom), 1'($urandom));
        end else if (pick < 11) begin
          send_item(OP_NOP, 8'($urandom), 1'($urandom));
        end else if (pick < 20 && eff > 0) begin
          send_item($urandom_range(1) ? OP_USE : OP_DEFINE,
                    8'($urandom_range(eff - 1)), 1'($urandom));
        end else if (pick < 55 && defined_q.size() > 0) begin
          send_item(OP_USE, defined_q[$urandom_range(defined_q.size() - 1)], 1'($urandom));
        end else begin
          num   = 8'($urandom_range(eff, VREGS - 1));
          known = 1'b0;
          foreach (defined_q[k]) if (defined_q[k] == num) known = 1'b1;
          if (known) begin
            send_item(OP_USE, num, 1'($urandom));
          end else begin
            defined_q.push_back(num);
            send_item(OP_DEFINE, num, 1'($urandom));
          end
        end
        sent++;
      end
    end
  endtask

  initial begin
    sb = new();
    send_idle = 16;
    recv_idle = 77;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part under the reset settings: pass-through at both ends of
    // the real range, plain defines and uses, a no-op, an undefined use that
    // aborts the procedure, an empty float class and a redefine.
    set_config(32'd32, 32'hFFFF_FFFF, 32'h0);
    send_item(OP_BEGIN,  8'd0,   1'b0);
    send_item(OP_USE,    8'd0,   1'b0);
    send_item(OP_DEFINE, 8'd31,  1'b1);
    send_item(OP_DEFINE, 8'd32,  1'b0);
    send_item(OP_DEFINE, 8'd255, 1'b0);
    send_item(OP_USE,    8'd255, 1'b1);
    send_item(OP_NOP,    8'd170, 1'b1);
    send_item(OP_USE,    8'd100, 1'b0);
    send_item(OP_USE,    8'd255, 1'b0);
    send_item(OP_NOP,    8'd85,  1'b0);
    send_item(OP_BEGIN,  8'd255, 1'b1);
    send_item(OP_DEFINE, 8'd60,  1'b1);
    send_item(OP_BEGIN,  8'd0,   1'b0);
    send_item(OP_DEFINE, 8'd60,  1'b0);
    send_item(OP_DEFINE, 8'd60,  1'b1);
    drain();

    // Two real ids: the integer class has a single register that is reused,
    // the float class wraps around and reclaims its first owner. A reclaimed
    // register still counts as defined.
    set_config(32'd2, 32'h2, 32'h3);
    send_item(OP_BEGIN,  8'd0,  1'b0);
    send_item(OP_DEFINE, 8'd10, 1'b0);
    send_item(OP_DEFINE, 8'd11, 1'b0);
    send_item(OP_USE,    8'd11, 1'b0);
    send_item(OP_USE,    8'd10, 1'b0);
    send_item(OP_BEGIN,  8'd0,  1'b0);
    send_item(OP_DEFINE, 8'd2,  1'b1);
    send_item(OP_DEFINE, 8'd3,  1'b1);
    send_item(OP_DEFINE, 8'd4,  1'b1);
    send_item(OP_DEFINE, 8'd2,  1'b0);
    drain();

    // Random part: six settings, two per idling phase. The settings include
    // full masks, a single real id, no real ids at all, a count above the
    // number of real ids and random counts with stray upper data bits.
    for (int s = 0; s < 6; s++) begin
      case (s / 2)
        0: begin send_idle = 16; recv_idle = 77; end
        1: begin send_idle = 77; recv_idle = 16; end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      case (s)
        0: set_config(32'd32, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        1: set_config(32'd1, 32'h1, 32'h1);
        2: set_config(32'd0, 32'h0, $urandom);
        3: set_config(32'd63, $urandom, $urandom);
        4: set_config($urandom_range(2, 31), $urandom, $urandom);
        default: set_config(($urandom & 32'hFFFF_FFC0) | $urandom_range(1, 32),
                            $urandom, $urandom);
      endcase
      // With no idling on either side, one long receiver hold-off backs the
      // block up while the sender keeps offering transactions.
      if (s == 4) hold_req <= 1'b1;
      run_procedures(SUB_ITEMS);
      drain();
    end

    repeat (20) @(posedge clk);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("round_robin_register_allocator test passed");
    end else begin
      $display("round_robin_register_allocator test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
